[rtl/core/memory_map_range_splitter_assert.svh]
// Assertion macros used by the splitter back end.
// Both use clk and rst of the including module and hold off during reset.
`ifndef MEMORY_MAP_RANGE_SPLITTER_ASSERT_SVH
`define MEMORY_MAP_RANGE_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define MMRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MMRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mmrs_pkg.sv]
package mmrs_pkg;

  localparam int AddrW     = 64;
  localparam int TypeW     = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 64;
  localparam int MaxPieces = 3;
  localparam int CountW    = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RESERVE_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESERVE_SIZE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESERVED_TYPE = 2'd2;

  // piece counts per incoming entry
  localparam logic [CountW-1:0] PIECES_ONE   = 2'd1;
  localparam logic [CountW-1:0] PIECES_TWO   = 2'd2;
  localparam logic [CountW-1:0] PIECES_THREE = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] entry_base;
    logic [AddrW-1:0] entry_size;
    logic [TypeW-1:0] entry_type;
    logic             map_last_in;
  } in_word_t;

  typedef struct packed {
    logic [AddrW-1:0] out_base;
    logic [AddrW-1:0] out_size;
    logic [TypeW-1:0] out_type;
    logic             run_last;
    logic             map_last_out;
  } out_word_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] size;
    logic [TypeW-1:0] type_code;
  } piece_t;

  // one classified entry: its pieces in address order
  typedef struct packed {
    piece_t [MaxPieces-1:0] pieces;
    logic [CountW-1:0]      count;
    logic                   map_last;
  } rec_t;

endpackage

[rtl/core/mmrs_front.sv]
module mmrs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  mmrs_pkg::in_word_t               entry,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mmrs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mmrs_pkg::CfgDataW-1:0]    cfg_data,
  output logic                             rec_valid,
  input  logic                             rec_full,
  output mmrs_pkg::rec_t                   rec
);

  localparam int AW = mmrs_pkg::AddrW;
  localparam int TW = mmrs_pkg::TypeW;

  // configuration registers
  logic [AW-1:0] reserve_base;
  logic [AW-1:0] reserve_size;
  logic [TW-1:0] reserved_type;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_base  <= '0;
      reserve_size  <= '0;
      reserved_type <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mmrs_pkg::CFG_RESERVE_BASE:  reserve_base  <= cfg_data[AW-1:0];
        mmrs_pkg::CFG_RESERVE_SIZE:  reserve_size  <= cfg_data[AW-1:0];
        mmrs_pkg::CFG_RESERVED_TYPE: reserved_type <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // stage A: ends, start compare, start difference
  logic          a_valid;
  logic [AW-1:0] a_base, a_size, a_diff;
  logic [TW-1:0] a_type;
  logic          a_last, a_base_gt;
  logic [AW:0]   a_entry_end, a_res_end;

  // stage B: overlap bounds
  logic          b_valid;
  logic [AW-1:0] b_base, b_size, b_head_len, b_ov_start;
  logic [TW-1:0] b_type;
  logic          b_last, b_start_is_base;
  logic [AW:0]   b_entry_end, b_ov_end;

  // stage C: classified record
  logic          c_valid;
  mmrs_pkg::rec_t c_rec;

  logic adv_a, adv_b, adv_c;
  logic rdy_a, rdy_b, rdy_c;

  // elastic ready chain back from the queue
  assign rdy_c = !c_valid || !rec_full;
  assign rdy_b = !b_valid || rdy_c;
  assign rdy_a = !a_valid || rdy_b;
  assign full  = !rdy_a;

  assign adv_a = push && rdy_a;
  assign adv_b = a_valid && rdy_b;
  assign adv_c = b_valid && rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (rdy_a) a_valid <= push;
      if (rdy_b) b_valid <= a_valid;
      if (rdy_c) c_valid <= b_valid;
    end
  end

  // stage A payload
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_base      <= entry.entry_base;
      a_size      <= entry.entry_size;
      a_type      <= entry.entry_type;
      a_last      <= entry.map_last_in;
      a_entry_end <= {1'b0, entry.entry_base} + {1'b0, entry.entry_size};
      a_res_end   <= {1'b0, reserve_base} + {1'b0, reserve_size};
      a_base_gt   <= entry.entry_base > reserve_base;
      a_diff      <= reserve_base - entry.entry_base;
    end
  end

  // stage B payload: overlap start is the larger start, end the smaller end
  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_base          <= a_base;
      b_size          <= a_size;
      b_type          <= a_type;
      b_last          <= a_last;
      b_entry_end     <= a_entry_end;
      b_ov_start      <= a_base_gt ? a_base : reserve_base;
      b_ov_end        <= (a_entry_end < a_res_end) ? a_entry_end : a_res_end;
      b_start_is_base <= a_base_gt || (a_diff == '0);
      b_head_len      <= a_diff;
    end
  end

  // stage C: classify and lay out the pieces
  logic           c_nonempty, c_end_eq;
  logic [AW-1:0]  c_ov_len, c_tail_len;
  mmrs_pkg::rec_t c_rec_next;

  always_comb begin
    c_nonempty = {1'b0, b_ov_start} < b_ov_end;
    c_end_eq   = b_ov_end == b_entry_end;
    c_ov_len   = b_ov_end[AW-1:0] - b_ov_start;
    c_tail_len = b_entry_end[AW-1:0] - b_ov_end[AW-1:0];

    c_rec_next          = '0;
    c_rec_next.map_last = b_last;
    if (!c_nonempty) begin
      // no overlap: pass through
      c_rec_next.count     = mmrs_pkg::PIECES_ONE;
      c_rec_next.pieces[0] = '{base: b_base, size: b_size, type_code: b_type};
    end else if (b_start_is_base) begin
      if (c_end_eq) begin
        // fully covered: retype
        c_rec_next.count     = mmrs_pkg::PIECES_ONE;
        c_rec_next.pieces[0] = '{base: b_base, size: b_size, type_code: reserved_type};
      end else begin
        c_rec_next.count     = mmrs_pkg::PIECES_TWO;
        c_rec_next.pieces[0] = '{base: b_base, size: c_ov_len, type_code: reserved_type};
        c_rec_next.pieces[1] = '{base: b_ov_end[AW-1:0], size: c_tail_len,
                                 type_code: b_type};
      end
    end else begin
      // head, reserved part, optional tail
      c_rec_next.count     = c_end_eq ? mmrs_pkg::PIECES_TWO : mmrs_pkg::PIECES_THREE;
      c_rec_next.pieces[0] = '{base: b_base, size: b_head_len, type_code: b_type};
      c_rec_next.pieces[1] = '{base: b_ov_start, size: c_ov_len, type_code: reserved_type};
      c_rec_next.pieces[2] = '{base: b_ov_end[AW-1:0], size: c_tail_len,
                               type_code: b_type};
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) c_rec <= c_rec_next;
  end

  assign rec_valid = c_valid;
  assign rec       = c_rec;

endmodule

[rtl/core/mmrs_fifo.sv]
module mmrs_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  mmrs_pkg::rec_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output mmrs_pkg::rec_t rd_data,
  output logic           q_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mmrs_pkg::rec_t   mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr, do_rd;

  assign q_full  = count == CntW'(DEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

[rtl/core/mmrs_back.sv]
`include "memory_map_range_splitter_assert.svh"

module mmrs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  mmrs_pkg::rec_t        rec,
  output logic                  rec_pop,
  output logic                  empty,
  input  logic                  pop,
  output mmrs_pkg::out_word_t   result
);

  logic [mmrs_pkg::CountW-1:0] idx;
  logic                        out_valid;
  mmrs_pkg::out_word_t         word;
  mmrs_pkg::out_word_t         word_next;
  mmrs_pkg::piece_t            sel;
  logic                        load, last_piece;

  // output register takes the next piece when free or being drained
  assign load       = rec_valid && (!out_valid || pop);
  assign last_piece = idx == (rec.count - 1'b1);
  assign rec_pop    = load && last_piece;

  always_comb begin
    case (idx)
      2'd0:    sel = rec.pieces[0];
      2'd1:    sel = rec.pieces[1];
      2'd2:    sel = rec.pieces[2];
      default: sel = rec.pieces[0];
    endcase
    word_next.out_base     = sel.base;
    word_next.out_size     = sel.size;
    word_next.out_type     = sel.type_code;
    word_next.run_last     = last_piece;
    word_next.map_last_out = last_piece && rec.map_last;
  end

  // piece index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) idx <= last_piece ? '0 : idx + 1'b1;
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) word <= word_next;
  end

  assign empty  = !out_valid;
  assign result = word;

  `MMRS_ASSERT_NOW(a_count_nonzero, rec_valid, rec.count != '0, "record with no pieces")
  `MMRS_ASSERT_NOW(a_idx_in_range, rec_valid, idx < rec.count, "piece index past count")
  `MMRS_ASSERT_NOW(a_map_last_on_run_last, out_valid && word.map_last_out, word.run_last,
                   "map end flag without run end")
  `MMRS_ASSERT_NEXT(a_idx_wraps, rec_pop, idx == '0, "piece index not cleared after run")

endmodule

[rtl/core/memory_map_range_splitter.sv]
// Memory-map range splitter.
// Path: front stages A, B, C, then the queue, then the output register on the result side.
// Throughput: one result word per cycle while the reader pops, so an entry gives 1 to 3 words on the
// result port (one per piece); the back-end sequencer is the limit.
// Reset (rst, synchronous): clears the reserved range and type to 0 and empties
// all pipeline stages and the queue.
module memory_map_range_splitter #(
  parameter int QueueDepth = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  mmrs_pkg::in_word_t             entry,
  output logic                           empty,
  input  logic                           pop,
  output mmrs_pkg::out_word_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmrs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mmrs_pkg::CfgDataW-1:0]  cfg_data
);

  logic           f_valid, q_full, q_empty, q_pop;
  mmrs_pkg::rec_t f_rec, q_rec;

  mmrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .entry     (entry),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_valid (f_valid),
    .rec_full  (q_full),
    .rec       (f_rec)
  );

  mmrs_fifo #(.DEPTH(QueueDepth)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_valid),
    .wr_data (f_rec),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rec),
    .q_empty (q_empty)
  );

  mmrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!q_empty),
    .rec       (q_rec),
    .rec_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
